>>> hdl/ipid_pkg.sv
// Shared types and constants of the incremental PID controller.
`default_nettype none

package ipid_pkg;

   // Width of a stored coefficient, signed, with the data fraction bits.
   localparam int COEF_W = 48;
   // Magnitude bits of a coefficient or a ratio; the largest value is all ones.
   localparam int COEF_MAG_W = COEF_W - 1;
   // Magnitude bits of one product term before the sum.
   localparam int TERM_MAG_W = 60;
   // Signed width of one product term.
   localparam int TERM_W = TERM_MAG_W + 1;
   // A full product at or above two to this power is treated as an overflow.
   localparam int WRAP_W = 64;
   // Width of the register index on the configuration port.
   localparam int CSR_INDEX_W = 3;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SETPOINT      = 3'd0,
      CSR_GAIN          = 3'd1,
      CSR_SAMPLE_PERIOD = 3'd2,
      CSR_DERIV_TIME    = 3'd3,
      CSR_INTEGRAL_TIME = 3'd4
   } csr_index_type;

   // Controller sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_RD,
      ST_DIV_RI,
      ST_MUL_Q0,
      ST_MUL_Q1,
      ST_MUL_Q2,
      ST_MUL_T0,
      ST_MUL_T1,
      ST_MUL_T2,
      ST_FINISH
   } ipid_state_type;

endpackage

`default_nettype wire

>>> hdl/incremental_pid_controller.sv
// Incremental PID controller top level with a bit-serial multiplier and divider.
`default_nettype none

// Velocity-form discrete PID controller in signed fixed point with FRAC_BITS
// fraction bits. Each measured sample gives one result: the accumulated drive
// after adding q0*e + q1*e[n-1] + q2*e[n-2], the error e = setpoint - measured,
// and a flag that is set when the error, a product term or the drive was
// clipped. All multiplies go through one shared shift-and-add multiplier
// that consumes one bit of a DATA_WIDTH-bit operand per cycle. An item runs
// through the three product phases and a final step, and the next item can
// be accepted once the sequencer is back in idle after loading its result
// into the output register, even while that result still waits to be taken.
// A write to the gain, sample period, derivative time or integral time
// recomputes the coefficients: two restoring divisions and three multiplies;
// csr_ready and req_stall hold the block off during that time. A setpoint
// write does not start a recompute.
module incremental_pid_controller
   import ipid_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Measured sample input.
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [DATA_WIDTH-1:0]  req_measured,
   // Result output.
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [DATA_WIDTH-1:0]       rsp_drive,
   output logic [DATA_WIDTH-1:0]       rsp_error_now,
   output logic                        rsp_saturated,
   // Configuration write port.
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [DATA_WIDTH-1:0]  csr_data
);

   // Derived widths.
   localparam int TW    = DATA_WIDTH - 1;
   localparam int AW    = COEF_W + 1;
   localparam int OP1_W = AW + 1;
   localparam int PW    = AW + DATA_WIDTH;
   localparam int DVW   = DATA_WIDTH - 1 + FRAC_BITS;
   localparam int SW    = ((DATA_WIDTH > TERM_W) ? DATA_WIDTH : TERM_W) + 2;
   localparam int CW    = $clog2(DVW + 2);

   localparam logic [CW-1:0]         MUL_LAST = CW'(DATA_WIDTH + 1);
   localparam logic [CW-1:0]         DIV_LAST = CW'(DVW + 1);
   localparam logic [DATA_WIDTH-1:0] ONE_DATA = DATA_WIDTH'(1) << FRAC_BITS;
   localparam logic [TW-1:0]         ONE_TIME = TW'(1) << FRAC_BITS;
   localparam logic [TW-1:0]         TIME_LSB = TW'(1);
   localparam logic [COEF_W-1:0]     ONE_COEF = COEF_W'(1) << FRAC_BITS;
   localparam logic [OP1_W-1:0]      ONE_OP   = OP1_W'(1) << FRAC_BITS;
   localparam logic [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   // Sequencer.
   ipid_state_type state_ff, state_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           is_div, is_work, phase_load, phase_last;

   // Configuration registers and coefficients.
   logic [DATA_WIDTH-1:0] setpoint_ff, setpoint_in;
   logic [DATA_WIDTH-1:0] gain_ff, gain_in;
   logic [TW-1:0]         t0_ff, t0_in;
   logic [TW-1:0]         td_ff, td_in;
   logic [TW-1:0]         ti_ff, ti_in;
   logic [COEF_W-1:0]     q0_ff, q0_in, q1_ff, q1_in, q2_ff, q2_in;

   // Loop state.
   logic [DATA_WIDTH-1:0] drive_accum_ff, drive_accum_in;
   logic [DATA_WIDTH-1:0] err_prev1_ff, err_prev1_in;
   logic [DATA_WIDTH-1:0] err_prev2_ff, err_prev2_in;

   // Per-item working registers.
   logic [DATA_WIDTH-1:0] err_ff, err_in;
   logic [SW-1:0]         sum_ff, sum_in;
   logic                  clip_ff, clip_in;

   // Coefficient working registers.
   logic [COEF_MAG_W-1:0] rd_ff, rd_in, ri_ff, ri_in;
   logic [OP1_W-1:0]      op1_ff, op1_in;

   // Divider.
   logic [TW-1:0]         div_rem_ff, div_rem_in;
   logic [TW-1:0]         div_den_ff, div_den_in;
   logic [DVW-1:0]        div_nq_ff, div_nq_in;
   logic [DATA_WIDTH-1:0] div_trial, div_diff;
   logic                  div_ge;
   logic [COEF_MAG_W-1:0] ratio_val;

   // Multiplier.
   logic [AW-1:0]         mul_a_ff, mul_a_in;
   logic [PW-1:0]         mul_p_ff, mul_p_in;
   logic                  mul_neg_ff, mul_neg_in;
   logic [AW:0]           mul_sum;
   logic [PW-1:0]         mul_shifted;
   logic                  mul_big, coef_clip, term_clip;
   logic [COEF_MAG_W-1:0] coef_mag;
   logic [TERM_MAG_W-1:0] term_mag;
   logic [COEF_W-1:0]     coef_val;
   logic [SW-1:0]         sum_term;

   // Operand selection.
   logic [AW-1:0]         ld_a;
   logic [DATA_WIDTH-1:0] ld_ser;
   logic                  ld_neg;
   logic [DATA_WIDTH-1:0] gain_mag, err_mag, e1_mag, e2_mag;
   logic [COEF_W-1:0]     q0_abs, q1_abs, q2_abs;
   logic [OP1_W-1:0]      op1_abs;
   logic [AW-1:0]         op0;
   logic [TW-1:0]         t0_eff, ti_eff;

   // Error and drive saturation.
   logic [DATA_WIDTH:0]   err_diff;
   logic                  err_ovf;
   logic [DATA_WIDTH-1:0] err_sat;
   logic                  drive_ovf;
   logic [DATA_WIDTH-1:0] drive_sat;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_drive_ff, rsp_drive_in;
   logic [DATA_WIDTH-1:0] rsp_error_ff, rsp_error_in;
   logic                  rsp_sat_ff, rsp_sat_in;

   // Handshakes.
   logic item_accept, csr_write, recompute, out_free;

   assign item_accept = req_valid && !req_stall;
   assign csr_write   = csr_valid && csr_ready;
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   // Coefficient inputs that change the coefficients when written.
   always_comb begin
      unique case (csr_index)
         CSR_GAIN, CSR_SAMPLE_PERIOD, CSR_DERIV_TIME, CSR_INTEGRAL_TIME: recompute = csr_write;
         default: recompute = 1'b0;
      endcase
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (recompute) begin
               state_in = ST_DIV_RD;
            end else if (item_accept) begin
               state_in = ST_MUL_T0;
            end
         end
         ST_DIV_RD: if (phase_last) state_in = ST_DIV_RI;
         ST_DIV_RI: if (phase_last) state_in = ST_MUL_Q0;
         ST_MUL_Q0: if (phase_last) state_in = ST_MUL_Q1;
         ST_MUL_Q1: if (phase_last) state_in = ST_MUL_Q2;
         ST_MUL_Q2: if (phase_last) state_in = ST_IDLE;
         ST_MUL_T0: if (phase_last) state_in = ST_MUL_T1;
         ST_MUL_T1: if (phase_last) state_in = ST_MUL_T2;
         ST_MUL_T2: if (phase_last) state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: handshake and phase flags.
   always_comb begin
      is_div  = (state_ff == ST_DIV_RD) || (state_ff == ST_DIV_RI);
      is_work = (state_ff != ST_IDLE) && (state_ff != ST_FINISH);
      phase_load = is_work && (cnt_ff == '0);
      phase_last = is_work && (cnt_ff == (is_div ? DIV_LAST : MUL_LAST));
      csr_ready  = (state_ff == ST_IDLE);
      req_stall  = (state_ff != ST_IDLE) || csr_valid;
   end

   // Operand magnitudes.
   assign gain_mag = gain_ff[DATA_WIDTH-1] ? -gain_ff : gain_ff;
   assign err_mag  = err_ff[DATA_WIDTH-1] ? -err_ff : err_ff;
   assign e1_mag   = err_prev1_ff[DATA_WIDTH-1] ? -err_prev1_ff : err_prev1_ff;
   assign e2_mag   = err_prev2_ff[DATA_WIDTH-1] ? -err_prev2_ff : err_prev2_ff;
   assign q0_abs   = q0_ff[COEF_W-1] ? -q0_ff : q0_ff;
   assign q1_abs   = q1_ff[COEF_W-1] ? -q1_ff : q1_ff;
   assign q2_abs   = q2_ff[COEF_W-1] ? -q2_ff : q2_ff;
   assign op1_abs  = op1_ff[OP1_W-1] ? -op1_ff : op1_ff;
   assign op0      = AW'(rd_ff) + AW'(ONE_COEF);
   assign t0_eff   = (t0_ff == '0) ? TIME_LSB : t0_ff;
   assign ti_eff   = (ti_ff == '0) ? TIME_LSB : ti_ff;

   // Multiplier operands for each phase.
   always_comb begin
      ld_a   = '0;
      ld_ser = '0;
      ld_neg = 1'b0;
      unique case (state_ff)
         ST_MUL_Q0: begin
            ld_a   = op0;
            ld_ser = gain_mag;
            ld_neg = gain_ff[DATA_WIDTH-1];
         end
         ST_MUL_Q1: begin
            ld_a   = op1_abs[AW-1:0];
            ld_ser = gain_mag;
            ld_neg = !(gain_ff[DATA_WIDTH-1] ^ op1_ff[OP1_W-1]);
         end
         ST_MUL_Q2: begin
            ld_a   = AW'(rd_ff);
            ld_ser = gain_mag;
            ld_neg = gain_ff[DATA_WIDTH-1];
         end
         ST_MUL_T0: begin
            ld_a   = AW'(q0_abs);
            ld_ser = err_mag;
            ld_neg = q0_ff[COEF_W-1] ^ err_ff[DATA_WIDTH-1];
         end
         ST_MUL_T1: begin
            ld_a   = AW'(q1_abs);
            ld_ser = e1_mag;
            ld_neg = q1_ff[COEF_W-1] ^ err_prev1_ff[DATA_WIDTH-1];
         end
         ST_MUL_T2: begin
            ld_a   = AW'(q2_abs);
            ld_ser = e2_mag;
            ld_neg = q2_ff[COEF_W-1] ^ err_prev2_ff[DATA_WIDTH-1];
         end
         default: ;
      endcase
   end

   // Shift-and-add step and product post-processing.
   assign mul_sum     = {1'b0, mul_p_ff[PW-1:DATA_WIDTH]} +
                        (mul_p_ff[0] ? {1'b0, mul_a_ff} : '0);
   assign mul_shifted = mul_p_ff >> FRAC_BITS;
   assign mul_big     = (mul_p_ff >> WRAP_W) != '0;
   assign coef_clip   = mul_big || ((mul_p_ff >> (FRAC_BITS + COEF_MAG_W)) != '0);
   assign term_clip   = mul_big || ((mul_p_ff >> (FRAC_BITS + TERM_MAG_W)) != '0);
   assign coef_mag    = coef_clip ? '1 : mul_shifted[COEF_MAG_W-1:0];
   assign term_mag    = term_clip ? '1 : mul_shifted[TERM_MAG_W-1:0];
   assign coef_val    = mul_neg_ff ? -{1'b0, coef_mag} : {1'b0, coef_mag};
   assign sum_term    = mul_neg_ff ? (sum_ff - SW'(term_mag)) : (sum_ff + SW'(term_mag));

   // Restoring divider step and ratio saturation.
   assign div_trial = {div_rem_ff, div_nq_ff[DVW-1]};
   assign div_ge    = div_trial >= {1'b0, div_den_ff};
   assign div_diff  = div_trial - {1'b0, div_den_ff};
   assign ratio_val = ((div_nq_ff >> COEF_MAG_W) != '0) ? '1 : COEF_MAG_W'(div_nq_ff);

   // Error of the incoming sample, clipped to the data range.
   assign err_diff = {setpoint_ff[DATA_WIDTH-1], setpoint_ff} -
                     {req_measured[DATA_WIDTH-1], req_measured};
   assign err_ovf  = err_diff[DATA_WIDTH] != err_diff[DATA_WIDTH-1];
   assign err_sat  = err_ovf ? (err_diff[DATA_WIDTH] ? DATA_MIN : DATA_MAX)
                             : err_diff[DATA_WIDTH-1:0];

   // New drive, clipped to the data range.
   assign drive_ovf = !((&sum_ff[SW-1:DATA_WIDTH-1]) || !(|sum_ff[SW-1:DATA_WIDTH-1]));
   assign drive_sat = drive_ovf ? (sum_ff[SW-1] ? DATA_MIN : DATA_MAX)
                                : sum_ff[DATA_WIDTH-1:0];

   // Next values of the datapath registers.
   always_comb begin
      cnt_in         = (is_work && !phase_last) ? cnt_ff + 1'b1 : '0;
      setpoint_in    = setpoint_ff;
      gain_in        = gain_ff;
      t0_in          = t0_ff;
      td_in          = td_ff;
      ti_in          = ti_ff;
      q0_in          = q0_ff;
      q1_in          = q1_ff;
      q2_in          = q2_ff;
      drive_accum_in = drive_accum_ff;
      err_prev1_in   = err_prev1_ff;
      err_prev2_in   = err_prev2_ff;
      err_in         = err_ff;
      sum_in         = sum_ff;
      clip_in        = clip_ff;
      rd_in          = rd_ff;
      ri_in          = ri_ff;
      op1_in         = op1_ff;
      div_rem_in     = div_rem_ff;
      div_den_in     = div_den_ff;
      div_nq_in      = div_nq_ff;
      mul_a_in       = mul_a_ff;
      mul_p_in       = mul_p_ff;
      mul_neg_in     = mul_neg_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_drive_in   = rsp_drive_ff;
      rsp_error_in   = rsp_error_ff;
      rsp_sat_in     = rsp_sat_ff;

      // Configuration writes.
      if (csr_write) begin
         unique case (csr_index)
            CSR_SETPOINT:      setpoint_in = csr_data;
            CSR_GAIN:          gain_in     = csr_data;
            CSR_SAMPLE_PERIOD: t0_in       = csr_data[TW-1:0];
            CSR_DERIV_TIME:    td_in       = csr_data[TW-1:0];
            CSR_INTEGRAL_TIME: ti_in       = csr_data[TW-1:0];
            default: ;
         endcase
      end

      // A new sample: latch its error and start the sum from the drive.
      if (item_accept) begin
         err_in  = err_sat;
         clip_in = err_ovf;
         sum_in  = {{(SW-DATA_WIDTH){drive_accum_ff[DATA_WIDTH-1]}}, drive_accum_ff};
      end

      // Divider phases.
      if (is_div) begin
         if (phase_load) begin
            div_rem_in = '0;
            if (state_ff == ST_DIV_RD) begin
               div_nq_in  = {td_ff, {FRAC_BITS{1'b0}}};
               div_den_in = t0_eff;
            end else begin
               div_nq_in  = {t0_eff, {FRAC_BITS{1'b0}}};
               div_den_in = ti_eff;
            end
         end else if (phase_last) begin
            if (state_ff == ST_DIV_RD) begin
               rd_in = ratio_val;
            end else begin
               ri_in = ratio_val;
            end
         end else begin
            div_rem_in = div_ge ? div_diff[TW-1:0] : div_trial[TW-1:0];
            div_nq_in  = {div_nq_ff[DVW-2:0], div_ge};
         end
      end

      // The q1 operand is formed once both ratios are known.
      if (state_ff == ST_MUL_Q0 && phase_load) begin
         op1_in = ONE_OP + (OP1_W'(rd_ff) << 1) - OP1_W'(ri_ff);
      end

      // Multiplier phases.
      if (is_work && !is_div) begin
         if (phase_load) begin
            mul_a_in   = ld_a;
            mul_p_in   = PW'(ld_ser);
            mul_neg_in = ld_neg;
         end else if (phase_last) begin
            unique case (state_ff)
               ST_MUL_Q0: q0_in = coef_val;
               ST_MUL_Q1: q1_in = coef_val;
               ST_MUL_Q2: q2_in = coef_val;
               default: begin
                  sum_in  = sum_term;
                  clip_in = clip_ff || term_clip;
               end
            endcase
         end else begin
            mul_p_in = {mul_sum, mul_p_ff[DATA_WIDTH-1:1]};
         end
      end

      // Result: update the loop state and load the output register.
      if (state_ff == ST_FINISH && out_free) begin
         drive_accum_in = drive_sat;
         err_prev2_in   = err_prev1_ff;
         err_prev1_in   = err_ff;
         rsp_valid_in   = 1'b1;
         rsp_drive_in   = drive_sat;
         rsp_error_in   = err_ff;
         rsp_sat_in     = clip_ff || drive_ovf;
      end
   end

   // Control state, configuration and loop state, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         setpoint_ff    <= '0;
         gain_ff        <= ONE_DATA;
         t0_ff          <= ONE_TIME;
         td_ff          <= '0;
         ti_ff          <= ONE_TIME;
         q0_ff          <= ONE_COEF;
         q1_ff          <= '0;
         q2_ff          <= '0;
         drive_accum_ff <= '0;
         err_prev1_ff   <= '0;
         err_prev2_ff   <= '0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
         setpoint_ff    <= setpoint_in;
         gain_ff        <= gain_in;
         t0_ff          <= t0_in;
         td_ff          <= td_in;
         ti_ff          <= ti_in;
         q0_ff          <= q0_in;
         q1_ff          <= q1_in;
         q2_ff          <= q2_in;
         drive_accum_ff <= drive_accum_in;
         err_prev1_ff   <= err_prev1_in;
         err_prev2_ff   <= err_prev2_in;
      end
   end

   // Working payload registers.
   always_ff @(posedge clock) begin
      err_ff       <= err_in;
      sum_ff       <= sum_in;
      clip_ff      <= clip_in;
      rd_ff        <= rd_in;
      ri_ff        <= ri_in;
      op1_ff       <= op1_in;
      div_rem_ff   <= div_rem_in;
      div_den_ff   <= div_den_in;
      div_nq_ff    <= div_nq_in;
      mul_a_ff     <= mul_a_in;
      mul_p_ff     <= mul_p_in;
      mul_neg_ff   <= mul_neg_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_error_ff <= rsp_error_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   // Output ports.
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive     = rsp_drive_ff;
   assign rsp_error_now = rsp_error_ff;
   assign rsp_saturated = rsp_sat_ff;

   // A result appears only out of the final step of an item.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("result loaded outside the final step");

   // The phase counter never runs past the end of its phase.
   assert property (@(posedge clock) disable iff (reset)
      is_work |-> cnt_ff <= (is_div ? DIV_LAST : MUL_LAST))
      else $error("phase counter overrun");

   // A coefficient input write starts the recompute with the first division.
   assert property (@(posedge clock) disable iff (reset)
      recompute |=> state_ff == ST_DIV_RD)
      else $error("coefficient recompute did not start");

   // With the output register empty, the final step completes at once.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && !rsp_valid_ff) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result not delivered to an empty output register");

endmodule

`default_nettype wire
